[hw/rtl/lgs_pkg.sv]
// ----------------------------------------------------------------------------
// Life generation step package
// Shared widths, register indexes, reset values and types of the Life
// row-streaming block.
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam int unsigned ROW_W        = 64;
   localparam int unsigned ROW_IDX_W    = 12;
   localparam int unsigned COLS_W       = 7;
   localparam int unsigned ROWS_W       = 13;
   localparam int unsigned CSR_IDX_W    = 1;
   localparam int unsigned CSR_DATA_W   = 13;

   localparam int unsigned MAX_COLS_DEF = 64;
   localparam int unsigned MAX_ROWS_DEF = 4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b1;

   localparam logic [COLS_W-1:0] COLS_RST = 7'd64;
   localparam logic [ROWS_W-1:0] ROWS_RST = 13'd64;

   // Life rule thresholds, compared against the 3x3 sum including the centre
   localparam logic [3:0] SUM_BIRTH = 4'd3;
   localparam logic [3:0] SUM_KEEP  = 4'd4;

   typedef struct packed {
      logic [ROW_W-1:0]     next_row;
      logic [ROW_IDX_W-1:0] row_index;
      logic                 last_row;
   } result_type;

   // vertical live counts of one column: a over above/middle/current,
   // b over middle/current (row below taken as dead)
   typedef struct packed {
      logic [1:0] cnt_a;
      logic [1:0] cnt_b;
   } col_count_type;

   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctl_type;

endpackage

[hw/rtl/lgs_if.sv]
// ----------------------------------------------------------------------------
// Life generation step channels
// Valid/ready channels for incoming board rows and outgoing result rows.
// ----------------------------------------------------------------------------
interface lgs_req_if;
   logic                      valid;
   logic                      ready;
   logic [lgs_pkg::ROW_W-1:0] row_cells;

   modport source (output valid, output row_cells, input ready);
   modport sink   (input valid, input row_cells, output ready);
endinterface

interface lgs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lgs_pkg::ROW_W-1:0]     next_row;
   logic [lgs_pkg::ROW_IDX_W-1:0] row_index;
   logic                          last_row;

   modport source (output valid, output next_row, output row_index, output last_row,
                   input ready);
   modport sink   (input valid, input next_row, input row_index, input last_row,
                   output ready);
endinterface

[hw/rtl/lgs_cell.sv]
// ----------------------------------------------------------------------------
// Life column cell
// Holds the above and middle bits of one column, shares its vertical counts
// with both neighbours and works out the next state of its column.
// ----------------------------------------------------------------------------
module lgs_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lgs_pkg::cell_ctl_type  ctl,
   input  logic                   cur_bit,
   input  logic                   col_en,
   input  lgs_pkg::col_count_type left_cnt,
   input  lgs_pkg::col_count_type right_cnt,
   output lgs_pkg::col_count_type own_cnt,
   output logic                   next_a,
   output logic                   next_b
);

   logic above_ff, above_in;
   logic mid_ff, mid_in;
   logic a_bit, m_bit, c_bit;
   logic [3:0] sum_a, sum_b;

   // mask held bits again with the current width
   assign a_bit = above_ff & col_en;
   assign m_bit = mid_ff   & col_en;
   assign c_bit = cur_bit  & col_en;

   assign own_cnt.cnt_a = {1'b0, a_bit} + {1'b0, m_bit} + {1'b0, c_bit};
   assign own_cnt.cnt_b = {1'b0, m_bit} + {1'b0, c_bit};

   assign sum_a = {2'b00, left_cnt.cnt_a} + {2'b00, right_cnt.cnt_a}
                + {2'b00, own_cnt.cnt_a};
   assign sum_b = {2'b00, left_cnt.cnt_b} + {2'b00, right_cnt.cnt_b}
                + {2'b00, own_cnt.cnt_b};

   assign next_a = col_en & ((sum_a == lgs_pkg::SUM_BIRTH) |
                             (m_bit & (sum_a == lgs_pkg::SUM_KEEP)));
   assign next_b = col_en & ((sum_b == lgs_pkg::SUM_BIRTH) |
                             (c_bit & (sum_b == lgs_pkg::SUM_KEEP)));

   always_comb begin
      above_in = above_ff;
      mid_in   = mid_ff;
      if (ctl.clear) begin
         above_in = 1'b0;
         mid_in   = 1'b0;
      end else if (ctl.load) begin
         // advance: middle moves up unmasked, the new row is stored masked
         above_in = mid_ff;
         mid_in   = c_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff <= 1'b0;
         mid_ff   <= 1'b0;
      end else begin
         above_ff <= above_in;
         mid_ff   <= mid_in;
      end
   end

endmodule

[hw/rtl/lgs_out_queue.sv]
// ----------------------------------------------------------------------------
// Life result queue
// Two-entry output queue taking up to two results per cycle and releasing
// one beat per cycle while the consumer pops it.
// ----------------------------------------------------------------------------
module lgs_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_cnt,
   input  lgs_pkg::result_type push_first,
   input  lgs_pkg::result_type push_second,
   input  logic                pop,
   output lgs_pkg::result_type head,
   output logic                head_valid,
   output logic [1:0]          free_slots
);

   lgs_pkg::result_type q_ff [2];
   lgs_pkg::result_type q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] base;

   assign head       = q_ff[0];
   assign head_valid = (cnt_ff != 2'd0);
   assign base       = cnt_ff - {1'b0, pop};
   assign free_slots = 2'd2 - base;

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push_cnt != 2'd0) begin
         q_in[base[0]] = push_first;
      end
      if (push_cnt == 2'd2) begin
         q_in[1] = push_second;
      end
      cnt_in = base + push_cnt;
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

[hw/rtl/life_generation_step.sv]
// ----------------------------------------------------------------------------
// Life generation step
// One generation of B3/S23 Life, streamed one board row per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one board row per beat, top row first; bit k is column k.
//   rsp_chan returns next-generation rows with their row index and a last_row
//   flag on the final row of the frame.
//   Accepting row r queues the result of row r-1 for release. The last
//   row of a frame releases two beats: row r-1 and then row r itself.
//   The first row of a frame releases nothing (unless the frame is one row).
// Throughput: one row per cycle while the result queue has room, set by the column
//   cell chain, which updates all columns in parallel for each accepted row. The
//   last row of a frame adds one extra result beat to the two-entry result queue.
// Stall: a stalled rsp_chan holds its beat; req_chan keeps accepting while the
//   queue has room for the results the next row will produce.
// Reset: held rows and the row counter clear, width and height return to 64.
// csr_* writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module life_generation_step #(
   parameter int unsigned MAX_COLS = lgs_pkg::MAX_COLS_DEF,
   parameter int unsigned MAX_ROWS = lgs_pkg::MAX_ROWS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   lgs_req_if.sink                            req_chan,
   lgs_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [lgs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lgs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Frame height is bounded by both the parameter and the height register.
   localparam int unsigned ROWS_REG_MAX = 2**lgs_pkg::ROWS_W - 1;
   localparam int unsigned ROWS_LIM     = (MAX_ROWS < ROWS_REG_MAX) ? MAX_ROWS : ROWS_REG_MAX;
   localparam int unsigned CNT_W        = (ROWS_LIM > 1) ? $clog2(ROWS_LIM) : 1;
   localparam int unsigned RW           = CNT_W + 1;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [lgs_pkg::COLS_W-1:0] cols_ff;
   logic [lgs_pkg::ROWS_W-1:0] rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= lgs_pkg::COLS_RST;
         rows_ff <= lgs_pkg::ROWS_RST;
      end else if (csr_wr_en) begin
         if (csr_index == lgs_pkg::CSR_COLS) begin
            cols_ff <= csr_wdata[lgs_pkg::COLS_W-1:0];
         end
         if (csr_index == lgs_pkg::CSR_ROWS) begin
            rows_ff <= csr_wdata[lgs_pkg::ROWS_W-1:0];
         end
      end
   end

   // Saturate the height: zero acts as one, oversize clips to the limit.
   logic [lgs_pkg::ROWS_W-1:0] rows_sat;
   logic [RW-1:0]              rows_eff;

   assign rows_sat = (rows_ff == '0) ? lgs_pkg::ROWS_W'(1) :
                     (rows_ff > lgs_pkg::ROWS_W'(ROWS_LIM)) ? lgs_pkg::ROWS_W'(ROWS_LIM) :
                     rows_ff;
   assign rows_eff = RW'(rows_sat);

   // ---------------------------------------------------------------
   // Row counter and frame control
   // ---------------------------------------------------------------
   logic [CNT_W-1:0] count_ff, count_in;
   logic             is_first, is_last, accept, pop;
   logic [1:0]       need, free_slots;
   lgs_pkg::cell_ctl_type cell_ctl;

   assign is_first = (count_ff == '0);
   // a row at or past the end of the frame closes it, even after the
   // height shrinks mid-frame
   assign is_last  = (({1'b0, count_ff} + RW'(1)) >= rows_eff);

   // result beats the next row will release
   assign need = is_first ? (is_last ? 2'd1 : 2'd0) : (is_last ? 2'd2 : 2'd1);

   assign pop            = rsp_chan.valid & rsp_chan.ready;
   assign req_chan.ready = (need <= free_slots);
   assign accept         = req_chan.valid & req_chan.ready;

   assign cell_ctl.load  = accept & ~is_last;
   assign cell_ctl.clear = accept & is_last;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = is_last ? '0 : (count_ff + CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ---------------------------------------------------------------
   // Column cell chain: each cell passes its vertical counts to both
   // neighbours; the outer edges see dead columns.
   // ---------------------------------------------------------------
   lgs_pkg::col_count_type col_cnt [MAX_COLS];
   logic [lgs_pkg::ROW_W-1:0] next_a_row, next_b_row;

   for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
      lgs_pkg::col_count_type left_cnt, right_cnt;
      logic                   col_en;

      assign col_en = (cols_ff > lgs_pkg::COLS_W'(k));

      if (k == 0) begin : g_left_edge
         assign left_cnt = '0;
      end else begin : g_left
         assign left_cnt = col_cnt[k-1];
      end

      if (k == MAX_COLS - 1) begin : g_right_edge
         assign right_cnt = '0;
      end else begin : g_right
         assign right_cnt = col_cnt[k+1];
      end

      lgs_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .cur_bit   (req_chan.row_cells[k]),
         .col_en    (col_en),
         .left_cnt  (left_cnt),
         .right_cnt (right_cnt),
         .own_cnt   (col_cnt[k]),
         .next_a    (next_a_row[k]),
         .next_b    (next_b_row[k])
      );
   end

   // columns beyond the cell chain are always dead
   if (MAX_COLS < lgs_pkg::ROW_W) begin : g_dead_cols
      assign next_a_row[lgs_pkg::ROW_W-1:MAX_COLS] = '0;
      assign next_b_row[lgs_pkg::ROW_W-1:MAX_COLS] = '0;
   end

   // ---------------------------------------------------------------
   // Results: a is the row before the current one, b the current row
   // closing the frame with a dead row below.
   // ---------------------------------------------------------------
   lgs_pkg::result_type res_a, res_b, push_first, head;
   logic [1:0]          push_cnt;
   logic                head_valid;

   assign res_a.next_row  = next_a_row;
   assign res_a.row_index = lgs_pkg::ROW_IDX_W'(count_ff - CNT_W'(1));
   assign res_a.last_row  = 1'b0;

   assign res_b.next_row  = next_b_row;
   assign res_b.row_index = lgs_pkg::ROW_IDX_W'(count_ff);
   assign res_b.last_row  = 1'b1;

   assign push_first = is_first ? res_b : res_a;
   assign push_cnt   = accept ? need : 2'd0;

   lgs_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push_cnt    (push_cnt),
      .push_first  (push_first),
      .push_second (res_b),
      .pop         (pop),
      .head        (head),
      .head_valid  (head_valid),
      .free_slots  (free_slots)
   );

   assign rsp_chan.valid     = head_valid;
   assign rsp_chan.next_row  = head.next_row;
   assign rsp_chan.row_index = head.row_index;
   assign rsp_chan.last_row  = head.last_row;

endmodule

[hw/rtl/lgs_checker.sv]
// ----------------------------------------------------------------------------
// Life generation step checker
// Port-level assertions on result ordering, reset and flow control.
// ----------------------------------------------------------------------------
module lgs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lgs_pkg::ROW_W-1:0]     rsp_next_row,
   input logic [lgs_pkg::ROW_IDX_W-1:0] rsp_row_index,
   input logic                          rsp_last_row
);

   logic [lgs_pkg::ROW_IDX_W-1:0] exp_idx_ff;

   // track the row index the next result beat must carry
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_idx_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         exp_idx_ff <= rsp_last_row ? '0 : (rsp_row_index + lgs_pkg::ROW_IDX_W'(1));
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_row) &&
                                  $stable(rsp_row_index) && $stable(rsp_last_row))
      else $error("result beat dropped or changed while stalled");

   a_rsp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> rsp_row_index == exp_idx_ff)
      else $error("result row index out of sequence");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat offered straight after reset");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("row refused with nothing pending");

endmodule

bind life_generation_step lgs_checker u_lgs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_next_row  (rsp_chan.next_row),
   .rsp_row_index (rsp_chan.row_index),
   .rsp_last_row  (rsp_chan.last_row)
);
